[rtl/core/scan_point_line_association_core_defines.svh]
// Assertion macros for the point to line association core
`ifndef SCAN_POINT_LINE_ASSOCIATION_CORE_DEFINES_SVH
`define SCAN_POINT_LINE_ASSOCIATION_CORE_DEFINES_SVH
`define SPLA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SPLA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[rtl/core/spla_pkg.sv]
// ----------------------------------------------------------------------------
// spla_pkg
// Shared constants, types and CORDIC table for the association core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package spla_pkg;
	localparam int MaxLines = 64;
	localparam int IdxW = $clog2(MaxLines);
	localparam int CordicIters = 28;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_BEAM = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [2:0] REG_POSE_X = 3'd0;
	localparam logic [2:0] REG_POSE_Y = 3'd1;
	localparam logic [2:0] REG_HEADING = 3'd2;
	localparam logic [2:0] REG_MARGIN = 3'd3;
	localparam logic [2:0] REG_MAX_DIST = 3'd4;
	localparam logic [2:0] REG_FIRST_ANG = 3'd5;
	localparam logic [2:0] REG_ANG_STEP = 3'd6;
	localparam logic [2:0] REG_MAX_RANGE = 3'd7;

	localparam logic signed [47:0] TwoPi = 48'sd1686629713;
	localparam logic signed [47:0] Pi = 48'sd843314857;
	localparam logic signed [47:0] HalfPi = 48'sd421657428;
	localparam logic signed [33:0] CordicK = 34'sd652032874;
	localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

	typedef struct packed {
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] min_proj;
		logic signed [31:0] max_proj;
		logic signed [31:0] ncos;
		logic signed [31:0] nsin;
		logic signed [31:0] offset;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

	typedef struct packed {
		logic start;
		logic signed [47:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] c;
		logic signed [31:0] s;
	} cordic_rsp_t;

	function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
		logic signed [31:0] r;
		unique case (i)
			5'd0: r = 32'sd210828714;
			5'd1: r = 32'sd124459457;
			5'd2: r = 32'sd65760959;
			5'd3: r = 32'sd33381290;
			5'd4: r = 32'sd16755422;
			5'd5: r = 32'sd8385879;
			5'd6: r = 32'sd4193963;
			5'd7: r = 32'sd2097109;
			5'd8: r = 32'sd1048571;
			5'd9: r = 32'sd524287;
			default: r = 32'sd1 <<< (5'd28 - i);
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction
endpackage
`default_nettype wire

[rtl/core/spla_ram.sv]
// ----------------------------------------------------------------------------
// spla_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module spla_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/spla_cordic.sv]
// ----------------------------------------------------------------------------
// spla_cordic
// Iterative CORDIC: range reduction and a fold, then one rotation per
// cycle, 28 rotations. Returns clamped Q2.30 cosine and sine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module spla_cordic (
	input wire logic clk,
	input wire logic arst_n,
	input wire spla_pkg::cordic_req_t req,
	output spla_pkg::cordic_rsp_t rsp
);
	typedef enum logic [4:0] {
		C_IDLE = 5'b00001,
		C_MOD = 5'b00010,
		C_FOLD = 5'b00100,
		C_ROT = 5'b01000,
		C_OUT = 5'b10000
	} cstate_t;

	cstate_t state_q;
	logic signed [47:0] z_q;
	logic signed [33:0] x_q, y_q;
	logic flip_q;
	logic [4:0] it_q;
	logic [5:0] mod_q;
	logic signed [33:0] dx, dy, xo, yo;
	logic signed [47:0] zsub;

	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;
	assign zsub = spla_pkg::TwoPi <<< mod_q;
	assign xo = flip_q ? -x_q : x_q;
	assign yo = flip_q ? -y_q : y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			rsp.done <= 1'b0;
		end else begin
			rsp.done <= 1'b0;
			unique case (state_q)
				C_IDLE: if (req.start) begin
					state_q <= C_MOD;
					z_q <= req.angle;
					mod_q <= 6'd14;
					flip_q <= 1'b0;
				end
				C_MOD: begin
					// restoring reduction of |z| toward [0, 2pi) then sign fix
					if (z_q >= 0) begin
						if (z_q >= zsub) z_q <= z_q - zsub;
					end else begin
						if (z_q < -zsub) z_q <= z_q + zsub;
					end
					if (mod_q == 6'd0) state_q <= C_FOLD;
					else mod_q <= mod_q - 6'd1;
				end
				C_FOLD: begin
					logic signed [47:0] z1;
					z1 = (z_q < 0) ? z_q + spla_pkg::TwoPi : z_q;
					if (z1 > spla_pkg::Pi) z1 = z1 - spla_pkg::TwoPi;
					if (z1 > spla_pkg::HalfPi) begin
						z1 = z1 - spla_pkg::Pi;
						flip_q <= 1'b1;
					end else if (z1 < -spla_pkg::HalfPi) begin
						z1 = z1 + spla_pkg::Pi;
						flip_q <= 1'b1;
					end
					z_q <= z1;
					x_q <= spla_pkg::CordicK;
					y_q <= '0;
					it_q <= '0;
					state_q <= C_ROT;
				end
				C_ROT: begin
					if (z_q >= 0) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - 48'(spla_pkg::atan_q28(it_q));
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + 48'(spla_pkg::atan_q28(it_q));
					end
					if (it_q == 5'(spla_pkg::CordicIters - 1)) state_q <= C_OUT;
					else it_q <= it_q + 5'd1;
				end
				C_OUT: begin
					rsp.c <= (xo > spla_pkg::OneQ30) ? 32'sh40000000 :
						(xo < -spla_pkg::OneQ30) ? -32'sh40000000 : xo[31:0];
					rsp.s <= (yo > spla_pkg::OneQ30) ? 32'sh40000000 :
						(yo < -spla_pkg::OneQ30) ? -32'sh40000000 : yo[31:0];
					rsp.done <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/core/scan_point_line_association_core.sv]
// ----------------------------------------------------------------------------
// scan_point_line_association_core
// Map line table plus per-beam nearest-line search.
// ----------------------------------------------------------------------------
// One command at a time; busy is high while it runs. A write keeps busy high
// through one CORDIC run for the normal. A clear or an unused command is taken
// in the accepting cycle with no busy time. A dropped beam keeps busy high for
// 1 cycle. A kept beam keeps busy high through the front end plus the table
// scan. The front end is two CORDIC runs, each made of 15 reduction steps,
// fold, 28 rotations and output, and two multiply-register steps, one for the
// local point and one for the rotation. The scan passes over an invalid line
// in its read state and takes a valid one through RAM read, four parallel
// products, sums and compare. A kept beam's result appears on the result ports
// for one cycle with result_valid; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module scan_point_line_association_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] command,
	input wire logic [5:0] entry_index,
	input wire logic signed [31:0] seg_dir_x,
	input wire logic signed [31:0] seg_dir_y,
	input wire logic signed [31:0] seg_min_proj,
	input wire logic signed [31:0] seg_max_proj,
	input wire logic signed [31:0] seg_normal_angle,
	input wire logic signed [31:0] seg_offset,
	input wire logic [11:0] beam_number,
	input wire logic signed [31:0] beam_distance,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	output logic result_valid,
	output logic [11:0] out_beam_number,
	output logic matched,
	output logic [5:0] matched_line,
	output logic signed [31:0] point_local_x,
	output logic signed [31:0] point_local_y
);
	localparam int IW = spla_pkg::IdxW;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_WCOR = 12'b000000000010,
		S_BCOR = 12'b000000000100,
		S_LOC = 12'b000000001000,
		S_HCOR = 12'b000000010000,
		S_ROT1 = 12'b000000100000,
		S_ROT2 = 12'b000001000000,
		S_SREAD = 12'b000010000000,
		S_SM1 = 12'b000100000000,
		S_SM2 = 12'b001000000000,
		S_SCMP = 12'b010000000000,
		S_DONE = 12'b100000000000
	} state_t;

	state_t state_q;
	logic signed [31:0] pose_x_q, pose_y_q, heading_q, first_q, step_q;
	logic [30:0] margin_q, maxd_q, maxr_q;
	logic [spla_pkg::MaxLines-1:0] valid_q;

	logic [IW-1:0] widx_q;
	spla_pkg::entry_t went_q;
	logic [11:0] beam_q;
	logic signed [31:0] range_q, lx_q, ly_q, mx_q, my_q, bc_q, bs_q;
	logic signed [63:0] p1_q, p2_q, p3_q, p4_q;
	logic [IW:0] ridx_q;
	logic [IW-1:0] cidx_q;
	logic found_q;
	logic [IW-1:0] best_q;
	logic [31:0] bestd_q;
	logic signed [63:0] proj_s2, dot_s2;

	spla_pkg::cordic_req_t creq;
	spla_pkg::cordic_rsp_t crsp;
	logic ram_we;
	spla_pkg::entry_t ent;
	logic [spla_pkg::EntryW-1:0] ram_rd;

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign ent = spla_pkg::entry_t'(ram_rd);

	spla_cordic u_cordic (.clk(clk), .arst_n(arst_n), .req(creq), .rsp(crsp));

	spla_ram #(.Width(spla_pkg::EntryW), .Depth(spla_pkg::MaxLines)) u_tab (
		.clk(clk), .we(ram_we), .waddr(widx_q),
		.wdata({went_q.dir_x, went_q.dir_y, went_q.min_proj, went_q.max_proj,
			crsp.c, crsp.s, went_q.offset}),
		.raddr(ridx_q[IW-1:0]), .rdata(ram_rd));

	assign ram_we = (state_q == S_WCOR) && crsp.done;

	always_comb begin
		creq.start = 1'b0;
		creq.angle = '0;
		if (state_q == S_IDLE && start && command == spla_pkg::CMD_WRITE) begin
			creq.start = 1'b1;
			creq.angle = 48'(seg_normal_angle);
		end else if (state_q == S_IDLE && start && command == spla_pkg::CMD_BEAM &&
			beam_distance > 0 && beam_distance <= 32'(maxr_q)) begin
			creq.start = 1'b1;
			creq.angle = 48'(first_q) + 48'(step_q) * 48'(signed'({1'b0, beam_number}));
		end else if (state_q == S_LOC) begin
			creq.start = 1'b1;
			creq.angle = 48'(heading_q);
		end
	end

	logic signed [63:0] proj_lo, proj_hi, d_abs, dsum;
	always_comb begin
		proj_lo = 64'(ent.min_proj) - 64'(margin_q);
		proj_hi = 64'(ent.max_proj) + 64'(margin_q);
		dsum = dot_s2 - 64'(ent.offset);
		d_abs = (dsum < 0) ? -dsum : dsum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pose_x_q <= '0; pose_y_q <= '0; heading_q <= '0;
			first_q <= '0; step_q <= '0;
			margin_q <= '0; maxd_q <= '0; maxr_q <= '0;
			valid_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					spla_pkg::REG_POSE_X: pose_x_q <= cfg_data;
					spla_pkg::REG_POSE_Y: pose_y_q <= cfg_data;
					spla_pkg::REG_HEADING: heading_q <= cfg_data;
					spla_pkg::REG_MARGIN: margin_q <= cfg_data[30:0];
					spla_pkg::REG_MAX_DIST: maxd_q <= cfg_data[30:0];
					spla_pkg::REG_FIRST_ANG: first_q <= cfg_data;
					spla_pkg::REG_ANG_STEP: step_q <= cfg_data;
					spla_pkg::REG_MAX_RANGE: maxr_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (start) begin
					widx_q <= entry_index[IW-1:0];
					went_q.dir_x <= seg_dir_x;
					went_q.dir_y <= seg_dir_y;
					went_q.min_proj <= seg_min_proj;
					went_q.max_proj <= seg_max_proj;
					went_q.offset <= seg_offset;
					beam_q <= beam_number;
					range_q <= beam_distance;
					if (command == spla_pkg::CMD_WRITE) state_q <= S_WCOR;
					else if (command == spla_pkg::CMD_CLEAR) valid_q <= '0;
					else if (command == spla_pkg::CMD_BEAM && beam_distance > 0 &&
						beam_distance <= 32'(maxr_q)) state_q <= S_BCOR;
					else if (command == spla_pkg::CMD_BEAM) state_q <= S_DONE;
				end
				S_WCOR: if (crsp.done) begin
					valid_q[widx_q] <= 1'b1;
					state_q <= S_DONE;
				end
				S_BCOR: if (crsp.done) begin
					p1_q <= 64'(range_q) * 64'(crsp.c);
					p2_q <= 64'(range_q) * 64'(crsp.s);
					state_q <= S_LOC;
				end
				S_LOC: begin
					lx_q <= spla_pkg::sat32((p1_q + 64'sd536870912) >>> 30);
					ly_q <= spla_pkg::sat32((p2_q + 64'sd536870912) >>> 30);
					state_q <= S_HCOR;
				end
				S_HCOR: if (crsp.done) begin
					bc_q <= crsp.c;
					bs_q <= crsp.s;
					state_q <= S_ROT1;
				end
				S_ROT1: begin
					p1_q <= 64'(bc_q) * 64'(lx_q);
					p2_q <= 64'(bs_q) * 64'(ly_q);
					p3_q <= 64'(bs_q) * 64'(lx_q);
					p4_q <= 64'(bc_q) * 64'(ly_q);
					state_q <= S_ROT2;
				end
				S_ROT2: begin
					mx_q <= spla_pkg::sat32(64'(pose_x_q) +
						((p1_q - p2_q + 64'sd536870912) >>> 30));
					my_q <= spla_pkg::sat32(64'(pose_y_q) +
						((p3_q + p4_q + 64'sd536870912) >>> 30));
					ridx_q <= '0;
					found_q <= 1'b0;
					best_q <= '0;
					bestd_q <= '0;
					state_q <= S_SREAD;
				end
				S_SREAD: begin
					if (ridx_q == (IW+1)'(spla_pkg::MaxLines)) state_q <= S_DONE;
					else if (!valid_q[ridx_q[IW-1:0]]) ridx_q <= ridx_q + 1'b1;
					else begin
						cidx_q <= ridx_q[IW-1:0];
						state_q <= S_SM1;
					end
				end
				S_SM1: begin
					p1_q <= 64'(ent.dir_x) * 64'(mx_q);
					p2_q <= 64'(ent.dir_y) * 64'(my_q);
					p3_q <= 64'(ent.ncos) * 64'(mx_q);
					p4_q <= 64'(ent.nsin) * 64'(my_q);
					state_q <= S_SM2;
				end
				S_SM2: begin
					proj_s2 <= ((p1_q + 64'sd32768) >>> 16) + ((p2_q + 64'sd32768) >>> 16);
					dot_s2 <= (p3_q + p4_q + 64'sd536870912) >>> 30;
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (!(proj_s2 < proj_lo || proj_s2 > proj_hi) &&
						d_abs <= 64'(maxd_q) &&
						(!found_q || d_abs[31:0] < bestd_q)) begin
						found_q <= 1'b1;
						best_q <= cidx_q;
						bestd_q <= d_abs[31:0];
					end
					ridx_q <= ridx_q + 1'b1;
					state_q <= S_SREAD;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_SREAD && ridx_q == (IW+1)'(spla_pkg::MaxLines)) begin
				result_valid <= 1'b1;
				out_beam_number <= beam_q;
				matched <= found_q;
				matched_line <= found_q ? 6'(best_q) : 6'd0;
				point_local_x <= lx_q;
				point_local_y <= ly_q;
			end
		end
	end
endmodule
`default_nettype wire

[rtl/core/spla_checker.sv]
// ----------------------------------------------------------------------------
// spla_checker
// Port-level checks for the association core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "scan_point_line_association_core_defines.svh"
module spla_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [1:0] command,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic result_valid,
	input wire logic matched,
	input wire logic [5:0] matched_line
);
	`SPLA_ASSERT_IMP(a_no_cfg_busy, clk, arst_n, busy, !cfg_ready, "cfg ready while busy")
	`SPLA_ASSERT_NXT(a_write_busy, clk, arst_n, start && !busy && command == spla_pkg::CMD_WRITE, busy,
		"write did not go busy")
	`SPLA_ASSERT_IMP(a_res_in_cmd, clk, arst_n, result_valid, busy, "result outside a command")
	`SPLA_ASSERT_IMP(a_unmatched_zero, clk, arst_n, result_valid && !matched,
		matched_line == 6'd0, "unmatched result with nonzero line")
	`SPLA_ASSERT_NXT(a_single_res, clk, arst_n, result_valid, !result_valid,
		"back to back results")
endmodule

bind scan_point_line_association_core spla_checker u_spla_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
	.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .result_valid(result_valid),
	.matched(matched), .matched_line(matched_line));
`default_nettype wire
